// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; the including file supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, also evaluated during reset.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/b64_pkg.sv =====
// Shared types, constants and alphabet functions for the Base64 codec.
// Used by b64_step and base64_codec; depends on nothing.
package b64_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'd61;
	localparam logic [7:0] PLUS_CHAR  = 8'd43;
	localparam logic [7:0] SLASH_CHAR = 8'd47;
	localparam int unsigned MAX_RES   = 4;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic REG_MODE = 1'b0;

	// Results produced by one input beat.
	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][7:0] data;
		logic [3:0]      bad;
	} b64_res_t;

	typedef struct packed {
		logic [5:0] val;
		logic       bad;
	} b64_sext_t;

	function automatic logic [7:0] to_char(logic [5:0] v);
		logic [7:0] r;
		if (v == 6'd62) r = PLUS_CHAR;
		else if (v == 6'd63) r = SLASH_CHAR;
		else if (v <= 6'd25) r = 8'(v) + 8'd65;
		else if (v <= 6'd51) r = 8'(v) + 8'd71;
		else r = 8'(v) - 8'd4;
		return r;
	endfunction

	// Characters outside the alphabet keep their low six bits.
	function automatic b64_sext_t from_char(logic [7:0] c);
		b64_sext_t r;
		r.bad = 1'b0;
		if (c == PLUS_CHAR) r.val = 6'd62;
		else if (c == SLASH_CHAR) r.val = 6'd63;
		else if (c >= 8'd65 && c <= 8'd90) r.val = 6'(c - 8'd65);
		else if (c >= 8'd97 && c <= 8'd122) r.val = 6'(c - 8'd71);
		else if (c >= 8'd48 && c <= 8'd57) r.val = 6'(c + 8'd4);
		else begin
			r.val = c[5:0];
			r.bad = 1'b1;
		end
		return r;
	endfunction

	function automatic b64_res_t push(b64_res_t r, logic [7:0] d, logic b);
		b64_res_t o;
		o = r;
		if (r.cnt < 3'(MAX_RES)) begin
			o.data[r.cnt[1:0]] = d;
			o.bad[r.cnt[1:0]]  = b;
			o.cnt = r.cnt + 3'd1;
		end
		return o;
	endfunction

endpackage

// ===== hw/rtl/b64_in_if.sv =====
// Input channel of the Base64 codec: one byte or character per beat.
// Standalone; no package needed.
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/b64_out_if.sv =====
// Result channel of the Base64 codec: one character or byte per beat.
// Standalone; no package needed.
interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_end;
	logic       bad_char;

	modport source (output valid, output out_byte, output run_last, output stream_end,
		output bad_char, input ready);
	modport sink (input valid, input out_byte, input run_last, input stream_end,
		input bad_char, output ready);
endinterface

// ===== hw/rtl/base64_codec.sv =====
// Top level of the streaming Base64 codec: APB mode register, group logic
// and a four-entry result buffer. Depends on b64_pkg, b64_in_if, b64_out_if, b64_step.
//
//  channel   dir  handshake      payload
//  items     in   valid/ready    in_byte, in_last
//  results   out  valid/ready    out_byte, run_last, stream_end, bad_char
//  apb       in   psel/penable   paddr, pwdata -> prdata (pready tied high)
//
// All results of an input beat are formed combinationally and loaded into the
// result buffer, which then drains one beat per cycle while the sink is ready.
// An item with results holds the input until its final result is taken, one
// with none does not hold it; the next item is taken in the cycle the final
// result leaves. Reset clears the mode (encode) and the group state. A stalled
// result sink holds the input until the final result of the buffered item is taken.
module base64_codec import b64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b64_in_if.sink      items,
	b64_out_if.source   results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic            mode_q;
	logic            cfg_wr;
	logic            in_take;
	logic            out_take;
	b64_res_t        res;
	logic [3:0][7:0] buf_data_q;
	logic [3:0]      buf_bad_q;
	logic [2:0]      buf_cnt_q;
	logic            buf_last_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_MODE);
	assign prdata  = (paddr[2] == REG_MODE) ? {31'b0, mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_wr) begin
			mode_q <= pwdata[0];
		end
	end

	assign out_take    = results.valid && results.ready;
	assign items.ready = (buf_cnt_q == 3'd0) || (buf_cnt_q == 3'd1 && results.ready);
	assign in_take     = items.valid && items.ready;

	b64_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.clear   (cfg_wr),
		.take    (in_take),
		.in_byte (items.in_byte),
		.in_last (items.in_last),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
		end else if (in_take && res.cnt != 3'd0) begin
			buf_cnt_q <= res.cnt;
		end else if (out_take) begin
			buf_cnt_q <= buf_cnt_q - 3'd1;
		end
	end

	// The head of the buffer is always entry zero; taking a beat shifts it.
	always_ff @(posedge clk) begin
		if (in_take && res.cnt != 3'd0) begin
			buf_data_q <= res.data;
			buf_bad_q  <= res.bad;
			buf_last_q <= items.in_last;
		end else if (out_take) begin
			buf_data_q <= {8'd0, buf_data_q[3:1]};
			buf_bad_q  <= {1'b0, buf_bad_q[3:1]};
		end
	end

	assign results.valid      = (buf_cnt_q != 3'd0);
	assign results.out_byte   = buf_data_q[0];
	assign results.bad_char   = buf_bad_q[0];
	assign results.run_last   = (buf_cnt_q == 3'd1);
	assign results.stream_end = (buf_cnt_q == 3'd1) && buf_last_q;

endmodule

// ===== hw/rtl/b64_step.sv =====
// Group state of the codec and the single-pass logic that turns one input beat
// into up to four results. Depends on b64_pkg.
module b64_step import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode,
	input  logic       clear,
	input  logic       take,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output b64_res_t   res
);

	logic [23:0] group_bits_q;
	logic [1:0]  group_pos_q;
	logic        pad_seen_q;
	logic        group_bad_q;

	logic [23:0] nbits;
	logic [1:0]  npos;
	logic        nps;
	logic        nbad;

	always_comb begin
		b64_sext_t sx;
		logic [23:0] gb;
		res   = '0;
		nbits = group_bits_q;
		npos  = group_pos_q;
		nps   = pad_seen_q;
		nbad  = group_bad_q;
		sx    = from_char(in_byte);
		gb    = {group_bits_q[15:0], in_byte};
		if (mode == MODE_ENCODE) begin
			nbits = gb;
			if (group_pos_q >= 2'd2) begin
				res = push(res, to_char(gb[23:18]), 1'b0);
				res = push(res, to_char(gb[17:12]), 1'b0);
				res = push(res, to_char(gb[11:6]), 1'b0);
				res = push(res, to_char(gb[5:0]), 1'b0);
				nbits = '0;
				npos  = '0;
			end else begin
				npos = group_pos_q + 2'd1;
				if (in_last) begin
					if (group_pos_q == 2'd0) begin
						res = push(res, to_char(gb[7:2]), 1'b0);
						res = push(res, to_char({gb[1:0], 4'b0}), 1'b0);
						res = push(res, PAD_CHAR, 1'b0);
						res = push(res, PAD_CHAR, 1'b0);
					end else begin
						res = push(res, to_char(gb[15:10]), 1'b0);
						res = push(res, to_char(gb[9:4]), 1'b0);
						res = push(res, to_char({gb[3:0], 2'b0}), 1'b0);
						res = push(res, PAD_CHAR, 1'b0);
					end
					nbits = '0;
					npos  = '0;
				end
			end
			nps  = 1'b0;
			nbad = 1'b0;
		end else begin
			if (in_byte == PAD_CHAR) begin
				if (nps) begin
					res = push(res, nbits[11:4], nbad);
					nbits = '0; npos = '0; nps = 1'b0; nbad = 1'b0;
				end else if (npos == 2'd3) begin
					res = push(res, nbits[17:10], nbad);
					res = push(res, nbits[9:2], nbad);
					nbits = '0; npos = '0; nps = 1'b0; nbad = 1'b0;
				end else if (npos == 2'd2) begin
					nps  = 1'b1;
					npos = 2'd3;
				end
			end else begin
				// A pending "xx=" is closed as "xx==" before this character.
				if (nps) begin
					res = push(res, nbits[11:4], nbad);
					nbits = '0; npos = '0; nps = 1'b0; nbad = 1'b0;
				end
				nbad  = nbad | sx.bad;
				nbits = {nbits[17:0], sx.val};
				if (npos == 2'd3) begin
					res = push(res, nbits[23:16], nbad);
					res = push(res, nbits[15:8], nbad);
					res = push(res, nbits[7:0], nbad);
					nbits = '0; npos = '0; nps = 1'b0; nbad = 1'b0;
				end else begin
					npos = npos + 2'd1;
				end
			end
			if (in_last) begin
				if (nps || npos == 2'd2) begin
					res = push(res, nbits[11:4], nbad);
				end else if (npos == 2'd3) begin
					res = push(res, nbits[17:10], nbad);
					res = push(res, nbits[9:2], nbad);
				end
				nbits = '0; npos = '0; nps = 1'b0; nbad = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_bits_q <= '0;
			group_pos_q  <= '0;
			pad_seen_q   <= 1'b0;
			group_bad_q  <= 1'b0;
		end else if (clear) begin
			group_bits_q <= '0;
			group_pos_q  <= '0;
			pad_seen_q   <= 1'b0;
			group_bad_q  <= 1'b0;
		end else if (take) begin
			group_bits_q <= nbits;
			group_pos_q  <= npos;
			pad_seen_q   <= nps;
			group_bad_q  <= nbad;
		end
	end

endmodule

// ===== hw/rtl/b64_checker.sv =====
// Port-level checks for base64_codec, attached by the bind at the end.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module b64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       stream_end,
	input logic       pready
);

	`CHK_ASSERT(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)), "result beat changed while stalled")
	`CHK_ASSERT(a_no_in_when_stalled, (out_valid && !out_ready) |-> !in_ready, "input taken while results are stalled")
	`CHK_ASSERT(a_end_is_last, (out_valid && stream_end) |-> run_last, "stream end not on final beat of its item")
	`CHK_ASSERT(a_no_invent, (out_valid && out_ready && run_last) |=> (!out_valid || $past(in_valid && in_ready)), "result appeared without an input beat")
	`CHK_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind base64_codec b64_checker u_b64_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_byte   (results.out_byte),
	.run_last   (results.run_last),
	.stream_end (results.stream_end),
	.pready     (pready)
);
